>>> hdl/wav_riff_header_parser_macros.svh
// assertion macros for the wav riff header parser checker
// no dependencies; included by the checker file only
`ifndef WAV_RIFF_HEADER_PARSER_MACROS_SVH
`define WAV_RIFF_HEADER_PARSER_MACROS_SVH

// same-cycle implication
`define WRHP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define WRHP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/wrhp_pkg.sv
// types and constants for the wav riff header parser
// no dependencies; imported by the top level and its checker
`default_nettype none

package wrhp_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic        status;
    logic        fmt_found;
    logic [15:0] channel_count;
    logic [31:0] rate_hz;
    logic        data_found;
    logic [31:0] pcm_size;
    logic [31:0] pcm_offset;
  } result_t;

  typedef enum logic [1:0] {
    KIND_OTHER = 2'd0,
    KIND_FMT   = 2'd1,
    KIND_DATA  = 2'd2
  } chunk_kind_t;

  localparam logic [31:0] TAG_RIFF      = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE      = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT       = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA      = 32'h6461_7461;
  localparam logic [31:0] HDR_LEN       = 32'd8;
  localparam logic [31:0] POS_MAX       = 32'hFFFF_FFFF;
  localparam logic [32:0] NEXT_MAX      = 33'h1_FFFF_FFFF;
  localparam logic [32:0] FIRST_CHUNK   = 33'd12;
  localparam logic [4:0]  FMT_IDX_FIRST = 5'd4;
  localparam logic [4:0]  FMT_IDX_MAX   = 5'd16;

  // byte idx of a four-character tag, first character at idx 0
  function automatic logic [7:0] tag_byte(input logic [31:0] tag, input logic [1:0] idx);
    logic [4:0] sh;
    sh = {~idx, 3'b000};
    return 8'(tag >> sh);
  endfunction

endpackage

`default_nettype wire

>>> hdl/wav_riff_header_parser.sv
// riff/wave header parser: one file byte per word, one result word per file
// result: registered, valid in the cycle after the word marked last_byte is accepted
// throughput: one byte per cycle; input stalls only while a result is held and stalled
// reset (rst, synchronous): byte count 0, first chunk at byte 12, flags and captures cleared
// after each last byte the walk returns to that same reset state
`default_nettype none

module wav_riff_header_parser
  import wrhp_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    item_valid,
  output logic         item_stall,
  input  wire item_t   item,
  output logic         result_valid,
  input  wire logic    result_stall,
  output result_t      result
);

  logic [31:0] pos, pos_next;
  logic [32:0] next_start, next_start_next;
  logic [31:0] tag_shift, tag_shift_next;
  logic [31:0] length_shift, length_shift_next;
  chunk_kind_t kind, kind_next;
  logic        format_error, format_error_next;
  logic        hdr_active, hdr_active_next;
  logic [2:0]  hdr_idx, hdr_idx_next;
  logic [31:0] cur_start, cur_start_next;
  logic [4:0]  fmt_idx, fmt_idx_next;
  logic        past_end, past_end_next;
  logic        fmt_found, fmt_found_next;
  logic [15:0] channel_count, channel_count_next;
  logic [31:0] rate_hz, rate_hz_next;
  logic        data_found, data_found_next;
  logic [31:0] pcm_size, pcm_size_next;
  logic [31:0] pcm_offset, pcm_offset_next;
  result_t     result_next;
  logic        accept;

  assign item_stall = result_valid & result_stall;
  assign accept     = item_valid & ~item_stall;

  always_comb begin
    logic [7:0]  b;
    logic        hdr_start;
    logic [2:0]  rel;
    logic [31:0] base;
    logic [31:0] tag_cur;
    logic [31:0] tag_new;
    logic [31:0] len_cur;
    logic [31:0] len_new;
    logic [33:0] sum;
    logic        fmt_hit;
    logic        status_v;

    b         = item.data_byte;
    hdr_start = 1'b0;
    rel       = '0;
    base      = cur_start;
    tag_cur   = tag_shift;
    tag_new   = tag_shift;
    len_cur   = length_shift;
    len_new   = length_shift;
    sum       = '0;
    fmt_hit   = 1'b0;
    status_v  = 1'b0;

    pos_next           = pos;
    next_start_next    = next_start;
    tag_shift_next     = tag_shift;
    length_shift_next  = length_shift;
    kind_next          = kind;
    format_error_next  = format_error;
    hdr_active_next    = hdr_active;
    hdr_idx_next       = hdr_idx;
    cur_start_next     = cur_start;
    fmt_idx_next       = fmt_idx;
    past_end_next      = past_end;
    fmt_found_next     = fmt_found;
    channel_count_next = channel_count;
    rate_hz_next       = rate_hz;
    data_found_next    = data_found;
    pcm_size_next      = pcm_size;
    pcm_offset_next    = pcm_offset;
    result_next        = '0;

    if (accept) begin
      if (!past_end) begin
        if (pos < 32'd4 && b != tag_byte(TAG_RIFF, pos[1:0])) begin
          format_error_next = 1'b1;
        end
        if (pos >= 32'd8 && pos < 32'd12 && b != tag_byte(TAG_WAVE, pos[1:0])) begin
          format_error_next = 1'b1;
        end
        if (pos >= 32'd12) begin
          hdr_start = !hdr_active && ({1'b0, pos} == next_start);
          if (hdr_start || hdr_active) begin
            rel     = hdr_start ? 3'd0 : hdr_idx;
            base    = hdr_start ? pos : cur_start;
            tag_cur = hdr_start ? '0 : tag_shift;
            len_cur = hdr_start ? '0 : length_shift;
            if (hdr_start) begin
              cur_start_next = pos;
              kind_next      = KIND_OTHER;
            end
            hdr_active_next   = 1'b1;
            hdr_idx_next      = rel + 3'd1;
            length_shift_next = len_cur;
            if (!rel[2]) begin
              tag_new        = {tag_cur[23:0], b};
              tag_shift_next = tag_new;
              if (rel == 3'd3) begin
                if (tag_new == TAG_FMT) begin
                  kind_next          = KIND_FMT;
                  fmt_hit            = 1'b1;
                  fmt_found_next     = 1'b1;
                  channel_count_next = '0;
                  rate_hz_next       = '0;
                  fmt_idx_next       = FMT_IDX_FIRST;
                end else if (tag_new == TAG_DATA) begin
                  kind_next       = KIND_DATA;
                  data_found_next = 1'b1;
                  pcm_offset_next = base + HDR_LEN;
                  pcm_size_next   = '0;
                end
              end
            end else begin
              len_new           = len_cur | ({24'd0, b} << {rel[1:0], 3'b000});
              length_shift_next = len_new;
              if (kind == KIND_DATA) begin
                pcm_size_next = len_new;
              end
              if (rel == 3'd7) begin
                sum             = {2'b00, base} + {2'b00, len_new} + {2'b00, HDR_LEN};
                next_start_next = (sum > {1'b0, NEXT_MAX}) ? NEXT_MAX : sum[32:0];
                hdr_active_next = 1'b0;
              end
            end
          end
          // fmt payload bytes, counted from the latest fmt chunk start
          if (fmt_found && !fmt_hit) begin
            case (fmt_idx)
              5'd10:   channel_count_next = channel_count | {8'd0, b};
              5'd11:   channel_count_next = channel_count | {b, 8'd0};
              5'd12:   rate_hz_next       = rate_hz | {24'd0, b};
              5'd13:   rate_hz_next       = rate_hz | {16'd0, b, 8'd0};
              5'd14:   rate_hz_next       = rate_hz | {8'd0, b, 16'd0};
              5'd15:   rate_hz_next       = rate_hz | {b, 24'd0};
              default: ;
            endcase
            fmt_idx_next = (fmt_idx == FMT_IDX_MAX) ? FMT_IDX_MAX : fmt_idx + 5'd1;
          end
        end
        if (pos == POS_MAX) begin
          past_end_next = 1'b1;
        end else begin
          pos_next = pos + 32'd1;
        end
      end

      if (item.last_byte) begin
        status_v = format_error_next || (!past_end && pos < 32'd11);
        result_next.status = status_v;
        if (!status_v) begin
          result_next.fmt_found     = fmt_found_next;
          result_next.channel_count = channel_count_next;
          result_next.rate_hz       = rate_hz_next;
          result_next.data_found    = data_found_next;
          result_next.pcm_size      = pcm_size_next;
          result_next.pcm_offset    = pcm_offset_next;
        end
        // back to the start of a new file
        pos_next           = '0;
        next_start_next    = FIRST_CHUNK;
        tag_shift_next     = '0;
        length_shift_next  = '0;
        kind_next          = KIND_OTHER;
        format_error_next  = 1'b0;
        hdr_active_next    = 1'b0;
        hdr_idx_next       = '0;
        cur_start_next     = '0;
        fmt_idx_next       = '0;
        past_end_next      = 1'b0;
        fmt_found_next     = 1'b0;
        channel_count_next = '0;
        rate_hz_next       = '0;
        data_found_next    = 1'b0;
        pcm_size_next      = '0;
        pcm_offset_next    = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos           <= '0;
      next_start    <= FIRST_CHUNK;
      tag_shift     <= '0;
      length_shift  <= '0;
      kind          <= KIND_OTHER;
      format_error  <= 1'b0;
      hdr_active    <= 1'b0;
      hdr_idx       <= '0;
      cur_start     <= '0;
      fmt_idx       <= '0;
      past_end      <= 1'b0;
      fmt_found     <= 1'b0;
      channel_count <= '0;
      rate_hz       <= '0;
      data_found    <= 1'b0;
      pcm_size      <= '0;
      pcm_offset    <= '0;
    end else begin
      pos           <= pos_next;
      next_start    <= next_start_next;
      tag_shift     <= tag_shift_next;
      length_shift  <= length_shift_next;
      kind          <= kind_next;
      format_error  <= format_error_next;
      hdr_active    <= hdr_active_next;
      hdr_idx       <= hdr_idx_next;
      cur_start     <= cur_start_next;
      fmt_idx       <= fmt_idx_next;
      past_end      <= past_end_next;
      fmt_found     <= fmt_found_next;
      channel_count <= channel_count_next;
      rate_hz       <= rate_hz_next;
      data_found    <= data_found_next;
      pcm_size      <= pcm_size_next;
      pcm_offset    <= pcm_offset_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept && item.last_byte) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && item.last_byte) begin
      result <= result_next;
    end
  end

endmodule

`default_nettype wire

>>> hdl/wrhp_checker.sv
// port-level checks for the wav riff header parser, bound to the top level
// depends on wrhp_pkg and wav_riff_header_parser_macros.svh
`default_nettype none
`include "wav_riff_header_parser_macros.svh"

module wrhp_checker
  import wrhp_pkg::*;
(
  input wire logic    clk,
  input wire logic    rst,
  input wire logic    item_valid,
  input wire logic    item_stall,
  input wire item_t   item,
  input wire logic    result_valid,
  input wire logic    result_stall,
  input wire result_t result
);

  `WRHP_ASSERT_NEXT(a_result_held, clk, rst, result_valid && result_stall,
    result_valid && $stable(result), "stalled result word changed")

  `WRHP_ASSERT_NOW(a_stall_cause, clk, rst, item_stall,
    result_valid && result_stall, "input stalled with no stalled result")

  `WRHP_ASSERT_NOW(a_result_source, clk, rst, $rose(result_valid),
    $past(item_valid && !item_stall && item.last_byte), "result word without a last byte")

  `WRHP_ASSERT_NOW(a_bad_format_zero, clk, rst, result_valid && result.status,
    !result.fmt_found && !result.data_found && result.channel_count == 16'd0 &&
    result.rate_hz == 32'd0 && result.pcm_size == 32'd0 && result.pcm_offset == 32'd0,
    "invalid format word carries fields")

  `WRHP_ASSERT_NOW(a_fmt_fields, clk, rst, result_valid && !result.fmt_found,
    result.channel_count == 16'd0 && result.rate_hz == 32'd0,
    "fmt fields set without a fmt chunk")

endmodule

bind wav_riff_header_parser wrhp_checker u_wrhp_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .item         (item),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

`default_nettype wire

>>> tb/sv/testbench.sv
// testbench for wav_riff_header_parser: byte-wide wav files in, one parse result per file out
// self-checking against an internal riff/wave walker; needs wrhp_pkg and the parser rtl only
`timescale 1ns / 100ps

module testbench;
  import wrhp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned RANDOM_WORDS = 800;
  localparam int unsigned MIN_FILES = 20;
  localparam int unsigned HOLD_AT = 500;
  localparam int unsigned HOLD_CYCLES = 400;

  localparam result_t BAD_FILE = '{status: 1'b1, default: '0};
  localparam result_t BARE_HDR = '0;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       typed;
    result_t    want;
  } row_t;

  typedef struct packed {
    item_t   it;
    logic    typed;
    result_t want;
  } word_t;

  // short files at both byte extremes, a bare header, a header cut one byte short
  localparam row_t DIRECTED_ROWS [25] = '{
    '{8'h00, 1'b1, 1'b1, BAD_FILE},
    '{8'hFF, 1'b1, 1'b1, BAD_FILE},
    '{8'h52, 1'b0, 1'b0, '0},
    '{8'h49, 1'b0, 1'b0, '0},
    '{8'h46, 1'b0, 1'b0, '0},
    '{8'h46, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'h57, 1'b0, 1'b0, '0},
    '{8'h41, 1'b0, 1'b0, '0},
    '{8'h56, 1'b0, 1'b0, '0},
    '{8'h45, 1'b1, 1'b1, BARE_HDR},
    '{8'h52, 1'b0, 1'b0, '0},
    '{8'h49, 1'b0, 1'b0, '0},
    '{8'h46, 1'b0, 1'b0, '0},
    '{8'h46, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h57, 1'b0, 1'b0, '0},
    '{8'h41, 1'b0, 1'b0, '0},
    '{8'h56, 1'b1, 1'b1, BAD_FILE}
  };

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_stall;
  item_t   item = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;

  word_t   word_q[$];
  word_t   cur_word = '0;
  result_t pending_results[$];
  result_t predicted;
  result_t oldest;
  int unsigned words_in = 0;
  int unsigned words_total = 0;
  int unsigned failures = 0;
  int unsigned cycle_count = 0;

  int unsigned send_gap = 0, send_phase = 0;
  bit          send_calm = 1'b0;
  int unsigned rx_gap = 0, rx_phase = 0, rx_cycles = 0, hold_left = 0;
  bit          rx_calm = 1'b0;

  // parser state
  logic [31:0] byte_pos;
  logic [32:0] next_start;
  logic [31:0] tag_sr, len_sr;
  chunk_kind_t kind;
  logic        tag_bad, in_header, pos_stuck;
  logic [31:0] chunk_base, fmt_base;
  logic        fmt_seen, data_seen;
  logic [15:0] chan;
  logic [31:0] rate, pcm_len, pcm_start;

  wav_riff_header_parser DUT (
    .clk, .rst, .item_valid, .item_stall, .item, .result_valid, .result_stall, .result
  );

  always #1 clk = ~clk;

  function automatic void clear_parser();
    byte_pos = '0;
    next_start = FIRST_CHUNK;
    tag_sr = '0;
    len_sr = '0;
    kind = KIND_OTHER;
    tag_bad = 1'b0;
    in_header = 1'b0;
    pos_stuck = 1'b0;
    chunk_base = '0;
    fmt_base = '0;
    fmt_seen = 1'b0;
    data_seen = 1'b0;
    chan = '0;
    rate = '0;
    pcm_len = '0;
    pcm_start = '0;
  endfunction

  function automatic bit predict_byte(input item_t w, output result_t r);
    logic [31:0] p, rel;
    logic [33:0] n;
    logic [7:0]  b;
    bit          short_file;
    b = w.data_byte;
    p = byte_pos;
    r = '0;
    if (!pos_stuck) begin
      if (p < 4 && b != TAG_RIFF[24 - 8 * p[1:0] +: 8]) tag_bad = 1'b1;
      if (p >= 8 && p < 12 && b != TAG_WAVE[24 - 8 * p[1:0] +: 8]) tag_bad = 1'b1;
      if (p >= 12) begin
        if (!in_header && {1'b0, p} == next_start) begin
          in_header = 1'b1;
          chunk_base = p;
          tag_sr = '0;
          len_sr = '0;
          kind = KIND_OTHER;
        end
        if (in_header) begin
          rel = p - chunk_base;
          if (rel < 4) begin
            tag_sr = {tag_sr[23:0], b};
            if (rel == 3 && tag_sr == TAG_FMT) begin
              kind = KIND_FMT;
              fmt_base = chunk_base;
              fmt_seen = 1'b1;
              chan = '0;
              rate = '0;
            end else if (rel == 3 && tag_sr == TAG_DATA) begin
              kind = KIND_DATA;
              data_seen = 1'b1;
              pcm_len = '0;
              pcm_start = chunk_base + HDR_LEN;
            end
          end else begin
            len_sr = len_sr | (32'(b) << (8 * rel[1:0]));
            if (kind == KIND_DATA) pcm_len = len_sr;
            if (rel == 7) begin
              n = 34'(chunk_base) + 34'(len_sr) + 34'(HDR_LEN);
              next_start = (n > 34'(NEXT_MAX)) ? NEXT_MAX : n[32:0];
              in_header = 1'b0;
            end
          end
        end
        if (fmt_seen) begin
          rel = p - fmt_base;
          if (rel == 10 || rel == 11) chan = chan | (16'(b) << (8 * rel[0]));
          else if (rel >= 12 && rel <= 15) rate = rate | (32'(b) << (8 * rel[1:0]));
        end
      end
      if (p == POS_MAX) pos_stuck = 1'b1;
      else byte_pos = p + 1;
    end
    if (!w.last_byte) return 1'b0;
    short_file = !pos_stuck && p < 11;
    if (tag_bad || short_file) begin
      r.status = 1'b1;
    end else begin
      r.fmt_found = fmt_seen;
      r.channel_count = chan;
      r.rate_hz = rate;
      r.data_found = data_seen;
      r.pcm_size = pcm_len;
      r.pcm_offset = pcm_start;
    end
    clear_parser();
    return 1'b1;
  endfunction

  function automatic void put32(ref logic [7:0] f[$], input logic [31:0] v, input bit little);
    for (int i = 0; i < 4; i++) f.push_back(little ? v[8 * i +: 8] : v[24 - 8 * i +: 8]);
  endfunction

  function automatic void add_file();
    logic [7:0]  f[$];
    word_t       w;
    int unsigned shape, nchunks, k, cut, payload, idx;
    logic [31:0] tag, len;
    bit          huge;
    shape = $urandom_range(0, 99);
    put32(f, TAG_RIFF, 1'b0);
    put32(f, $urandom(), 1'b1);
    put32(f, TAG_WAVE, 1'b0);
    if (shape < 8) begin
      f.delete();
      repeat ($urandom_range(1, 30)) f.push_back(8'($urandom()));
    end else if (shape < 15) begin
      cut = $urandom_range(1, 11);
      while (f.size() > cut) void'(f.pop_back());
    end else begin
      nchunks = $urandom_range(0, 3);
      for (int c = 0; c < nchunks; c++) begin
        k = $urandom_range(0, 99);
        huge = ($urandom_range(0, 19) == 0);
        if (k < 35) begin
          tag = TAG_FMT;
          len = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : 16;
        end else if (k < 65) begin
          tag = TAG_DATA;
          len = $urandom_range(0, 24);
        end else begin
          tag = ($urandom_range(0, 1) == 0) ? $urandom() : TAG_FMT ^ (32'd1 << $urandom_range(0, 31));
          len = $urandom_range(0, 12);
        end
        if (huge) len = $urandom() | 32'h8000_0000;
        payload = huge ? $urandom_range(0, 20) : len;
        put32(f, tag, 1'b0);
        put32(f, len, 1'b1);
        repeat (payload) f.push_back(8'($urandom()));
        if (huge) break;
      end
      if (shape < 23) begin
        idx = $urandom_range(0, 7);
        if (idx >= 4) idx = idx + 4;
        f[idx] = f[idx] ^ 8'($urandom_range(1, 255));
      end else if (shape < 28 && f.size() > 12) begin
        idx = $urandom_range(12, f.size() - 1);
        f[idx] = f[idx] ^ 8'($urandom_range(1, 255));
      end
      if ($urandom_range(0, 3) == 0) begin
        cut = $urandom_range(12, f.size());
        while (f.size() > cut) void'(f.pop_back());
      end
    end
    foreach (f[i]) begin
      w.it.data_byte = f[i];
      w.it.last_byte = (i == f.size() - 1);
      w.typed = 1'b0;
      w.want = '0;
      word_q.push_back(w);
    end
  endfunction

  function automatic int unsigned next_gap(inout int unsigned phase, inout bit calm);
    int unsigned r;
    if (phase == 0) begin
      phase = $urandom_range(20, 300);
      calm = ($urandom_range(0, 3) == 0);
    end
    phase--;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic report(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    failures++;
  endtask

  task automatic compare_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) report($sformatf("%s got %h want %h", name, got, want));
  endtask

  // sender
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!item_valid || !item_stall) begin
      if (send_gap > 0) begin
        send_gap--;
        item_valid <= 1'b0;
      end else if (word_q.size() > 0) begin
        cur_word <= word_q[0];
        item <= word_q[0].it;
        void'(word_q.pop_front());
        item_valid <= 1'b1;
        send_gap = next_gap(send_phase, send_calm);
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // receiver, with one long hold-off partway through
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      rx_cycles++;
      if (rx_cycles == HOLD_AT) hold_left = HOLD_CYCLES;
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else if (rx_gap > 0) begin
        rx_gap--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
        rx_gap = next_gap(rx_phase, rx_calm);
      end
    end
  end

  // prediction on each accepted byte, checking on each accepted result word
  always @(posedge clk) begin
    if (!rst) begin
      if (item_valid && !item_stall) begin
        if (predict_byte(cur_word.it, predicted))
          pending_results.push_back(cur_word.typed ? cur_word.want : predicted);
        words_in++;
      end
      if (result_valid && !result_stall) begin
        if (pending_results.size() == 0) begin
          report("result word with no result pending");
        end else begin
          oldest = pending_results.pop_front();
          compare_field("status", result.status, oldest.status);
          compare_field("fmt_found", result.fmt_found, oldest.fmt_found);
          compare_field("channel_count", result.channel_count, oldest.channel_count);
          compare_field("rate_hz", result.rate_hz, oldest.rate_hz);
          compare_field("data_found", result.data_found, oldest.data_found);
          compare_field("pcm_size", result.pcm_size, oldest.pcm_size);
          compare_field("pcm_offset", result.pcm_offset, oldest.pcm_offset);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin : stimulus
    word_t       w;
    int unsigned files;
    clear_parser();
    foreach (DIRECTED_ROWS[i]) begin
      w.it.data_byte = DIRECTED_ROWS[i].data;
      w.it.last_byte = DIRECTED_ROWS[i].last;
      w.typed = DIRECTED_ROWS[i].typed;
      w.want = DIRECTED_ROWS[i].want;
      word_q.push_back(w);
    end
    files = 0;
    while (word_q.size() < $size(DIRECTED_ROWS) + RANDOM_WORDS || files < MIN_FILES) begin
      add_file();
      files++;
    end
    words_total = word_q.size();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    while (words_in != words_total || pending_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (failures == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
